>>> hdl/swm_pkg.sv
// Shared types and constants for the sliding window minimum unit.
// No dependencies; imported by every module of the block but swm_checker.
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int WL_W     = 11;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic start;   // launch a token at the selected cell
        logic shift;   // move the sample line one cell on
    } swm_ctl_t;

    // Running minimum travelling back towards cell 0
    typedef struct packed {
        logic    vld;
        sample_t min;
    } swm_tok_t;

endpackage

>>> hdl/swm_cell.sv
// One cell of the window chain: holds one past sample and one token slot.
// Depends on swm_pkg.
module swm_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  swm_pkg::swm_ctl_t ctl,
    input  logic             sel,
    input  swm_pkg::sample_t data_in,
    output swm_pkg::sample_t data_out,
    input  swm_pkg::swm_tok_t tok_in,
    output swm_pkg::swm_tok_t tok_out
);
    import swm_pkg::*;

    sample_t  data_reg;
    swm_tok_t tok_reg;
    swm_tok_t tok_next;

    always_comb begin
        tok_next = tok_reg;
        if (ctl.start && sel) begin
            tok_next.vld = 1'b1;
            tok_next.min = data_reg;
        end else if (tok_in.vld) begin
            tok_next.vld = 1'b1;
            tok_next.min = (data_reg < tok_in.min) ? data_reg : tok_in.min;
        end else begin
            tok_next.vld = 1'b0;
        end
    end

    // history payload is never reset; only entries of the current run are read
    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            data_reg <= data_in;
        end
        tok_reg.min <= tok_next.min;
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
        end else begin
            tok_reg.vld <= tok_next.vld;
        end
    end

    assign data_out = data_reg;
    assign tok_out  = tok_reg;

endmodule

>>> hdl/swm_chain.sv
// Row of swm_cell instances: sample line shifts away from cell 0,
// tokens walk back towards cell 0. Depends on swm_pkg and swm_cell.
module swm_chain #(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  swm_pkg::swm_ctl_t ctl,
    input  logic [IDX_W-1:0]  start_idx,
    input  swm_pkg::sample_t  shift_in,
    output swm_pkg::swm_tok_t tok_head
);
    import swm_pkg::*;

    sample_t  data_q [0:DEPTH-1];
    swm_tok_t tok_q  [0:DEPTH-1];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        sample_t  d_in;
        swm_tok_t t_in;
        logic     sel;

        if (k == 0) begin : g_first
            assign d_in = shift_in;
        end else begin : g_rest
            assign d_in = data_q[k-1];
        end

        if (k == DEPTH-1) begin : g_last
            assign t_in = '0;
        end else begin : g_mid
            assign t_in = tok_q[k+1];
        end

        assign sel = (start_idx == IDX_W'(k));

        swm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .sel      (sel),
            .data_in  (d_in),
            .data_out (data_q[k]),
            .tok_in   (t_in),
            .tok_out  (tok_q[k])
        );
    end

    assign tok_head = tok_q[0];

endmodule

>>> hdl/sliding_window_minimum_unit.sv
// Sliding window minimum unit: controller, config register, result register.
// Depends on swm_pkg and swm_chain.
//
//  channel | ports                    | carries
//  --------+--------------------------+--------------------------------------
//  input   | s_tvalid/s_tready/s_tdata| sample; s_tuser = new_sequence
//  result  | m_tvalid/m_tready/m_tdata| window_min; m_tuser = window_empty
//  config  | cfg_wr_en/cfg_wr_data    | window_length
//
// One request at a time. A token launched at cell w-1, w being the smaller of
// window_length (clamped to 1..WINDOW_MAX) and the samples held in the run,
// walks back one cell per cycle to cell 0 and carries the window minimum; an
// empty window launches no token and reports zero with window_empty set.
// Reset (aresetn low, synchronous) clears control and the sample count; the
// history needs no clearing pass. A stalled result holds in m_tdata/m_tuser
// and, once the unit is idle, the next request is taken as the result is taken.
module sliding_window_minimum_unit #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [swm_pkg::WL_W-1:0] cfg_wr_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [31:0]              s_tdata,   // [31:0] sample
    input  logic                     s_tuser,   // [0] new_sequence
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [31:0]              m_tdata,   // [31:0] window_min
    output logic                     m_tuser    // [0] window_empty
);
    import swm_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] wl_reg, wl_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    sample_t          sample_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    sample_t          m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;

    logic             accept;
    logic [CNT_W-1:0] seen_eff;
    logic [CNT_W-1:0] w_eff;
    logic [IDX_W-1:0] start_idx;
    swm_ctl_t         ctl;
    swm_tok_t         tok_head;

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign seen_eff  = s_tuser ? '0 : seen_reg;
    assign w_eff     = (wl_reg < seen_eff) ? wl_reg : seen_eff;
    assign start_idx = IDX_W'(w_eff - CNT_W'(1));

    assign ctl.start = accept && (w_eff != '0);
    assign ctl.shift = (state_reg == ST_SHIFT);

    // clamp the written length to 1..WINDOW_MAX
    always_comb begin
        wl_next = wl_reg;
        if (cfg_wr_en) begin
            if (cfg_wr_data == '0) begin
                wl_next = CNT_W'(1);
            end else if (32'(cfg_wr_data) > 32'(WINDOW_MAX)) begin
                wl_next = CNT_W'(WINDOW_MAX);
            end else begin
                wl_next = CNT_W'(cfg_wr_data);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        seen_next     = seen_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    seen_next = seen_eff;
                    if (w_eff == '0) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = '0;
                        m_tuser_next  = 1'b1;
                        state_next    = ST_SHIFT;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (tok_head.vld) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = tok_head.min;
                    m_tuser_next  = 1'b0;
                    state_next    = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (seen_reg < CNT_W'(WINDOW_MAX)) begin
                    seen_next = seen_reg + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wl_reg       <= CNT_W'(1);
            seen_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wl_reg       <= wl_next;
            seen_reg     <= seen_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= sample_t'(s_tdata);
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    swm_chain #(
        .DEPTH (WINDOW_MAX),
        .IDX_W (IDX_W)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .start_idx (start_idx),
        .shift_in  (sample_reg),
        .tok_head  (tok_head)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 32'(m_tdata_reg);
    assign m_tuser  = m_tuser_reg;

endmodule

>>> hdl/swm_checker.sv
// Port-level checks for sliding_window_minimum_unit, attached by bind.
// Depends only on the top level's ports.
module swm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // stalled result must hold
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // empty window always reports zero
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("empty window with non-zero minimum");

    // one request in flight at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // no result straight out of reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sliding_window_minimum_unit swm_checker u_swm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/swm_checker.sv
`timescale 1ns / 1ps
// Checker for the sliding window minimum unit: watches config, input and result
// channels, predicts each result and compares it. Depends on swm_pkg.
module swm_scoreboard #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [swm_pkg::WL_W-1:0] cfg_wr_data,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [31:0]              s_tdata,
    input  logic                     s_tuser,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [31:0]              m_tdata,
    input  logic                     m_tuser,
    output int                       errors,
    output int                       outstanding,
    output int                       results_seen,
    output int                       empty_seen
);
    import swm_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] lowest;
        logic                empty;
    } min_result_t;

    sample_t         hist [WINDOW_MAX];
    int unsigned     held;
    int unsigned     wr_pos;
    logic [WL_W-1:0] win_len;
    min_result_t     expected_mins [$];
    int              err_cnt;
    int              res_cnt;
    int              empty_cnt;

    initial begin
        errors       = 0;
        outstanding  = 0;
        results_seen = 0;
        empty_seen   = 0;
        err_cnt      = 0;
        res_cnt      = 0;
        empty_cnt    = 0;
        held         = 0;
        wr_pos       = 0;
        win_len      = 1;
    end

    // Minimum over the samples ahead of this one, then push it into the history
    function automatic min_result_t window_minimum(sample_t smp, logic fresh);
        int unsigned span;
        int unsigned pos;
        sample_t     best;
        min_result_t r;
        if (fresh)
            held = 0;
        span = (win_len == 0) ? 1 : win_len;
        if (span > WINDOW_MAX)
            span = WINDOW_MAX;
        if (span > held)
            span = held;
        best = '0;
        pos  = wr_pos;
        for (int k = 0; k < span; k++) begin
            pos = (pos + WINDOW_MAX - 1) % WINDOW_MAX;
            if (k == 0 || hist[pos] < best)
                best = hist[pos];
        end
        r.lowest = best;
        r.empty  = (span == 0);
        hist[wr_pos] = smp;
        wr_pos = (wr_pos + 1) % WINDOW_MAX;
        if (held < WINDOW_MAX)
            held++;
        return r;
    endfunction

    always @(posedge aclk) begin
        min_result_t want;
        if (!aresetn) begin
            held    = 0;
            wr_pos  = 0;
            win_len = 1;
            expected_mins.delete();
        end else begin
            if (cfg_wr_en)
                win_len = cfg_wr_data;
            if (s_tvalid && s_tready)
                expected_mins.push_back(window_minimum(sample_t'(s_tdata), s_tuser));
            if (m_tvalid && m_tready) begin
                res_cnt++;
                if (m_tuser)
                    empty_cnt++;
                if (expected_mins.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with no request pending: window_min %0d empty %0b",
                             $time, $signed(m_tdata), m_tuser);
                end else begin
                    want = expected_mins.pop_front();
                    if (m_tdata !== want.lowest) begin
                        err_cnt++;
                        $display("%0t: window_min mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.lowest), $signed(m_tdata));
                    end
                    if (m_tuser !== want.empty) begin
                        err_cnt++;
                        $display("%0t: window_empty mismatch: expected %0b, actual %0b",
                                 $time, want.empty, m_tuser);
                    end
                end
            end
        end
        errors       <= err_cnt;
        outstanding  <= expected_mins.size();
        results_seen <= res_cnt;
        empty_seen   <= empty_cnt;
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Top of the sliding window minimum bench: clock, reset, stimulus and verdict.
// Depends on swm_pkg, sliding_window_minimum_unit and swm_scoreboard.
module testbench;
    import swm_pkg::*;

    localparam int WINDOW_MAX   = 1024;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES  = 300;

    logic            aclk;
    logic            aresetn     = 1'b0;
    logic            cfg_wr_en   = 1'b0;
    logic [WL_W-1:0] cfg_wr_data = '0;
    logic            s_tvalid    = 1'b0;
    logic            s_tready;
    logic [31:0]     s_tdata     = '0;
    logic            s_tuser     = 1'b0;
    logic            m_tvalid;
    logic            m_tready    = 1'b0;
    logic [31:0]     m_tdata;
    logic            m_tuser;

    int errors;
    int outstanding;
    int results_seen;
    int empty_seen;

    int tx_idle_pct = 31;
    int rx_idle_pct = 31;
    int stall_gen   = 0;
    int stall_seen  = 0;
    int items_sent  = 0;
    int settings    = 0;

    sliding_window_minimum_unit #(
        .WINDOW_MAX(WINDOW_MAX)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    swm_scoreboard #(
        .WINDOW_MAX(WINDOW_MAX)
    ) u_scoreboard (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding),
        .results_seen(results_seen),
        .empty_seen  (empty_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Result side: random back-pressure, plus a long hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_gen != stall_seen) begin
                stall_seen = stall_gen;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_sample(input logic [31:0] smp, input logic fresh);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= fresh;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Stop offering and wait until every request has its result back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic set_window(input int unsigned len);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len[WL_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // Mostly full-range values, with extremes and a narrow band for ties
    function automatic logic [31:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            case ($urandom_range(3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (roll < 30)
            return $urandom_range(15) - 8;
        return $urandom();
    endfunction

    function automatic int unsigned pick_window();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            7:       return $urandom_range(25, 120);
            default: return $urandom_range(3, 24);
        endcase
    endfunction

    initial begin
        int random_start;
        int burst;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, sequence restarts, zero and oversized windows
        set_window(3);
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFE, 1'b1);
        send_sample(32'h0000_0005, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h8000_0000, 1'b1);
        set_window(0);
        send_sample(32'h1234_5678, 1'b0);
        send_sample(32'h8765_4321, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        set_window(2047);
        send_sample(32'h0000_0005, 1'b1);
        send_sample(32'h0000_0003, 1'b0);
        send_sample(32'h0000_0009, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);

        // Fill the whole history past wrap with a short window, then long ones over it
        random_start = items_sent;
        set_window($urandom_range(1, 6));
        send_sample(pick_sample(), 1'b1);
        repeat (WINDOW_MAX + 8) send_sample(pick_sample(), 1'b0);
        set_window(WINDOW_MAX);
        repeat (6) send_sample(pick_sample(), 1'b0);
        set_window(1500);
        repeat (4) send_sample(pick_sample(), 1'b0);
        set_window(1000);
        repeat (4) send_sample(pick_sample(), 1'b0);

        // Receiver holds off while the sender keeps offering
        set_window(5);
        tx_idle_pct = 0;
        stall_gen <= stall_gen + 1;
        repeat (40) send_sample(pick_sample(), $urandom_range(99) < 4);

        // Stretch with no idling on either side
        set_window(pick_window());
        rx_idle_pct <= 0;
        repeat (120) send_sample(pick_sample(), $urandom_range(99) < 4);

        tx_idle_pct = 31;
        rx_idle_pct <= 31;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            set_window(pick_window());
            burst = $urandom_range(20, 60);
            repeat (burst) send_sample(pick_sample(), $urandom_range(99) < 4);
        end

        drain_results();
        repeat (WINDOW_MAX + 4) @(posedge aclk);
        $display("Run: %0d samples over %0d window settings (0, 1..120, 1000, 1024, 1500, 2047).",
                 items_sent, settings);
        $display("Checked %0d results, %0d with an empty window; one long receiver hold-off.",
                 results_seen, empty_seen);
        if (errors == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
